[src/fmpa_pkg.sv]
// ============================================================================
// fmpa_pkg: shared types and constants of the flow meter pulse accumulator
// Holds the transaction payload structs, the operation codes passed from the
// front end to the back end, and the datapath widths of the rate divider.
// ============================================================================
package fmpa_pkg;

    // Width of the saturating pulse counter.
    localparam int COUNT_BITS = 32;
    // Dividend: pulses * 1000 in unsigned Q42.16.
    localparam int NUM_W      = COUNT_BITS + 26;
    // Divisor: elapsed milliseconds times pulses per liter.
    localparam int DEN_W      = 48;
    // Quotient width of the rate (unsigned Q16.16).
    localparam int RATE_W     = 32;

    // Input transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic        pin_level;
        logic [31:0] now_us;
        logic [31:0] now_ms;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic        flowing;
        logic [31:0] flow_rate;
        logic [30:0] volume;
        logic        start_event;
        logic        stop_event;
    } out_item_t;

    // Operation decoded by the front end.
    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_READ,
        OP_CLEAR,
        OP_IGNORE
    } op_t;

    // Entry of the queue between front and back end.
    typedef struct packed {
        op_t         op;
        logic        pin_level;
        logic [31:0] now_us;
        logic [31:0] now_ms;
    } cmd_t;

endpackage

[src/fmpa_front.sv]
// ============================================================================
// fmpa_front: input stage of the flow meter pulse accumulator
// Registers each accepted input transaction, decodes its mode into an
// operation code and hands it to the command queue.
// ============================================================================
module fmpa_front import fmpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd_item
);

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    logic stage_valid_reg;
    cmd_t stage_item_reg;
    cmd_t decoded;

    // Decode the mode field into an operation.
    always_comb begin
        decoded.pin_level = s_item.pin_level;
        decoded.now_us    = s_item.now_us;
        decoded.now_ms    = s_item.now_ms;
        case (s_item.mode)
            MODE_SAMPLE: decoded.op = OP_SAMPLE;
            MODE_READ:   decoded.op = OP_READ;
            MODE_CLEAR:  decoded.op = OP_CLEAR;
            default:     decoded.op = OP_IGNORE;
        endcase
    end

    // The stage takes a new transaction whenever it is empty or draining.
    assign s_ready   = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd_item  = stage_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            stage_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_item_reg <= decoded;
        end
    end

endmodule

[src/fmpa_queue.sv]
// ============================================================================
// fmpa_queue: two-entry command queue
// Decouples the front end from the back end so that either can stall
// without holding up the other until the queue is full.
// ============================================================================
module fmpa_queue import fmpa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_item
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[src/fmpa_div.sv]
// ============================================================================
// fmpa_div: sequential rate divider
// Restoring division producing one quotient bit per cycle. The quotient
// saturates to all ones when it does not fit in the rate width, which also
// covers a zero divisor.
// ============================================================================
module fmpa_div import fmpa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [RATE_W-1:0]  quotient
);

    localparam int HI_W   = NUM_W - RATE_W;
    localparam int STEP_W = $clog2(RATE_W);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [RATE_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic              overflow;

    // One trial subtraction per cycle.
    assign trial    = {rem_reg, quo_reg[RATE_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = (trial >= {1'b0, den_reg});
    // The quotient fits the rate width only if the upper dividend is below the divisor.
    assign overflow = (DEN_W'(num[NUM_W-1:RATE_W]) >= den);

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg <= den;
                if (overflow) begin
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= DEN_W'(num[NUM_W-1:RATE_W]);
                    quo_reg  <= num[RATE_W-1:0];
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg  <= {quo_reg[RATE_W-2:0], fits};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RATE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/fmpa_back.sv]
// ============================================================================
// fmpa_back: execution back end of the flow meter pulse accumulator
// Holds the configuration and the meter state, carries out pin samples,
// read updates and volume clears, and drives the result register.
// ============================================================================
module fmpa_back import fmpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    localparam logic [1:0] CFG_PULSES_PER_LITER = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_US      = 2'd1;
    localparam logic [1:0] CFG_EDGE_MODE        = 2'd2;
    localparam logic [1:0] CFG_READ_INTERVAL_MS = 2'd3;

    localparam logic [1:0] EDGE_FALL = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_BOTH = 2'd2;

    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    // ceil(2^32 / 15): exact quotient by 15 for 24-bit operands.
    localparam logic [28:0] RECIP_15  = 29'd286331154;
    localparam logic [30:0] VOL_MAX   = 31'h7FFFFFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PROD,
        B_START,
        B_DIV,
        B_SCALE,
        B_RECIP,
        B_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [15:0] ppl_reg, ppl_next;
    logic [15:0] debounce_reg, debounce_next;
    logic [1:0]  edge_mode_reg, edge_mode_next;
    logic [15:0] interval_reg, interval_next;

    // Meter state.
    logic [COUNT_BITS-1:0] pulse_count_reg, pulse_count_next;
    logic        pulse_seen_reg, pulse_seen_next;
    logic        window_reg, window_next;
    logic        prior_window_reg, prior_window_next;
    logic [31:0] rate_reg, rate_next;
    logic [30:0] volume_reg, volume_next;
    logic [31:0] last_ms_reg, last_ms_next;
    logic [31:0] last_us_reg, last_us_next;
    logic        prev_level_reg, prev_level_next;

    // Read update datapath.
    logic [COUNT_BITS-1:0] pulses_reg, pulses_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic             stop_reg, stop_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [31:0]      quo_reg, quo_next;
    logic [25:0]      scaled_reg, scaled_next;
    logic [20:0]      incr_reg, incr_next;

    // Result register.
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic                  out_free;
    logic                  div_done;
    logic [RATE_W-1:0]     div_quotient;
    logic                  fall;
    logic                  rise;
    logic                  hit;
    logic                  bounced;
    logic [31:0]           since_pulse;
    logic [31:0]           elapsed;
    logic [COUNT_BITS+9:0] pulses_k;
    logic [41:0]           quo_k;
    logic [52:0]           recip_prod;
    logic [31:0]           vol_sum;

    fmpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == B_START),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == B_IDLE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Edge detection and debounce window.
    assign fall        = prev_level_reg && !cmd_item.pin_level;
    assign rise        = !prev_level_reg && cmd_item.pin_level;
    assign since_pulse = cmd_item.now_us - last_us_reg;
    assign bounced     = (debounce_reg != 16'd0) && (since_pulse < 32'(debounce_reg));
    assign elapsed     = cmd_item.now_ms - last_ms_reg;

    always_comb begin
        case (edge_mode_reg)
            EDGE_FALL: hit = fall;
            EDGE_RISE: hit = rise;
            EDGE_BOTH: hit = fall || rise;
            default:   hit = 1'b0;
        endcase
    end

    // Arithmetic of the rate and volume steps; the divisor product is formed in the sequencer.
    assign pulses_k   = (COUNT_BITS+10)'(pulses_reg) * (COUNT_BITS+10)'(MS_PER_S);
    assign quo_k      = 42'(quo_reg) * 42'(MS_PER_S);
    assign recip_prod = 53'(scaled_reg[25:2]) * 53'(RECIP_15);
    assign vol_sum    = 32'(volume_reg) + 32'(incr_reg);

    // Next-state logic of the sequencer and the meter.
    always_comb begin
        state_next        = state_reg;
        ppl_next          = ppl_reg;
        debounce_next     = debounce_reg;
        edge_mode_next    = edge_mode_reg;
        interval_next     = interval_reg;
        pulse_count_next  = pulse_count_reg;
        pulse_seen_next   = pulse_seen_reg;
        window_next       = window_reg;
        prior_window_next = prior_window_reg;
        rate_next         = rate_reg;
        volume_next       = volume_reg;
        last_ms_next      = last_ms_reg;
        last_us_next      = last_us_reg;
        prev_level_next   = prev_level_reg;
        pulses_next       = pulses_reg;
        elapsed_next      = elapsed_reg;
        stop_next         = stop_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        quo_next          = quo_reg;
        scaled_next       = scaled_reg;
        incr_next         = incr_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_item_next       = m_item_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_PULSES_PER_LITER: ppl_next       = cfg_wdata;
                CFG_DEBOUNCE_US:      debounce_next  = cfg_wdata;
                CFG_EDGE_MODE:        edge_mode_next = cfg_wdata[1:0];
                CFG_READ_INTERVAL_MS: interval_next  = cfg_wdata;
                default:              ppl_next       = ppl_reg;
            endcase
        end

        case (state_reg)
            B_IDLE: begin
                if (cmd_valid && out_free) begin
                    m_valid_next            = 1'b1;
                    m_item_next.start_event = 1'b0;
                    m_item_next.stop_event  = 1'b0;
                    case (cmd_item.op)
                        OP_SAMPLE: begin
                            prev_level_next = cmd_item.pin_level;
                            if (hit && !bounced) begin
                                if (debounce_reg != 16'd0) begin
                                    last_us_next = cmd_item.now_us;
                                end
                                m_item_next.start_event = !window_reg;
                                if (pulse_count_reg != COUNT_MAX) begin
                                    pulse_count_next = pulse_count_reg + COUNT_BITS'(1);
                                end
                                window_next = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (elapsed >= 32'(interval_reg)) begin
                                pulse_count_next  = '0;
                                window_next       = 1'b0;
                                prior_window_next = window_reg;
                                last_ms_next      = cmd_item.now_ms;
                                stop_next         = prior_window_reg && !window_reg;
                                if (pulse_count_reg == '0) begin
                                    pulse_seen_next        = 1'b0;
                                    rate_next              = 32'd0;
                                    m_item_next.stop_event = stop_next;
                                end else begin
                                    // The rate needs the divider: hold the result.
                                    pulse_seen_next = 1'b1;
                                    pulses_next     = pulse_count_reg;
                                    elapsed_next    = elapsed;
                                    m_valid_next    = 1'b0;
                                    state_next      = B_PROD;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            volume_next = '0;
                        end
                        default: begin
                            volume_next = volume_reg;
                        end
                    endcase
                    m_item_next.flowing   = pulse_seen_next;
                    m_item_next.flow_rate = rate_next;
                    m_item_next.volume    = volume_next;
                end
            end
            B_PROD: begin
                num_next   = {pulses_k, 16'd0};
                den_next   = DEN_W'(elapsed_reg) * DEN_W'(ppl_reg);
                state_next = B_START;
            end
            B_START: begin
                state_next = B_DIV;
            end
            B_DIV: begin
                if (div_done) begin
                    quo_next   = div_quotient;
                    state_next = B_SCALE;
                end
            end
            B_SCALE: begin
                scaled_next = quo_k[41:16];
                state_next  = B_RECIP;
            end
            B_RECIP: begin
                incr_next  = recip_prod[52:32];
                state_next = B_DONE;
            end
            B_DONE: begin
                if (out_free) begin
                    rate_next   = quo_reg;
                    volume_next = (vol_sum > 32'(VOL_MAX)) ? VOL_MAX : vol_sum[30:0];
                    m_valid_next            = 1'b1;
                    m_item_next.flowing     = pulse_seen_reg;
                    m_item_next.flow_rate   = rate_next;
                    m_item_next.volume      = volume_next;
                    m_item_next.start_event = 1'b0;
                    m_item_next.stop_event  = stop_reg;
                    state_next              = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= B_IDLE;
            ppl_reg          <= 16'd396;
            debounce_reg     <= 16'd0;
            edge_mode_reg    <= EDGE_FALL;
            interval_reg     <= 16'd1000;
            pulse_count_reg  <= '0;
            pulse_seen_reg   <= 1'b0;
            window_reg       <= 1'b0;
            prior_window_reg <= 1'b0;
            rate_reg         <= '0;
            volume_reg       <= '0;
            last_ms_reg      <= '0;
            last_us_reg      <= '0;
            prev_level_reg   <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ppl_reg          <= ppl_next;
            debounce_reg     <= debounce_next;
            edge_mode_reg    <= edge_mode_next;
            interval_reg     <= interval_next;
            pulse_count_reg  <= pulse_count_next;
            pulse_seen_reg   <= pulse_seen_next;
            window_reg       <= window_next;
            prior_window_reg <= prior_window_next;
            rate_reg         <= rate_next;
            volume_reg       <= volume_next;
            last_ms_reg      <= last_ms_next;
            last_us_reg      <= last_us_next;
            prev_level_reg   <= prev_level_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Datapath registers of the read update and the result payload.
    always_ff @(posedge aclk) begin
        pulses_reg  <= pulses_next;
        elapsed_reg <= elapsed_next;
        stop_reg    <= stop_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        scaled_reg  <= scaled_next;
        incr_reg    <= incr_next;
        m_item_reg  <= m_item_next;
    end

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == B_DIV))
        else $error("divider finished outside the divide step");

    // A result never reports a flow start and a flow stop together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_item_reg.start_event && m_item_reg.stop_event))
        else $error("start and stop events in one result");

    // Without pulses in the last window the rate is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pulse_seen_reg |-> (rate_reg == 32'd0))
        else $error("nonzero rate without flow");

endmodule

[src/flow_meter_pulse_accumulator_core.sv]
// ============================================================================
// flow_meter_pulse_accumulator_core: flow meter pulse accumulator top level
// Counts debounced sensor edges and turns them into a Q16.16 flow rate and a
// saturating volume total. Front end, command queue and back end are split so
// each side stalls independently.
// ============================================================================
//
//   Channel   Ports                        Direction  Payload
//   input     s_valid / s_ready / s_item   in         in_item_t
//   result    m_valid / m_ready / m_item   out        out_item_t
//   config    cfg_we / cfg_index/cfg_wdata in         16-bit register write
//
// A sample, clear, early read or read over an empty window is handled in the
// idle state without holding the back end; a read with counted pulses holds
// the back end through the product, start, divide, scale, reciprocal and done
// steps, the bit-serial divider giving one quotient bit per cycle for 32 bits
// and then its done flag. A rate that saturates skips those bit steps.
// A short command passes the front stage, the queue and the result register.
// Reset is synchronous on aresetn low and needs no clearing pass.
// A stalled result holds the back end; the front stage and the two-entry
// queue keep accepting until they fill.
module flow_meter_pulse_accumulator_core import fmpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    logic front_valid;
    logic front_ready;
    cmd_t front_item;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_item;

    fmpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd_item  (front_item)
    );

    fmpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_item  (cmd_item)
    );

    fmpa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
